// File: rtl/eadcm_pkg.sv
// Shared constants and helpers for the Euler angle direction cosine matrix block.
// Holds the Q30 sine polynomial coefficients and rounding functions; no dependencies.
package eadcm_pkg;

  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned OUT_SHIFT      = 30 - COEF_FRAC_BITS;

  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
  localparam logic signed [31:0] SIN_C1  = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C3  = 32'sd693598668;
  localparam logic signed [31:0] SIN_C5  = 32'sd85569306;
  localparam logic signed [31:0] SIN_C7  = 32'sd5026995;
  localparam logic signed [31:0] SIN_C9  = 32'sd172272;

  // Pipeline depth: one sine/cosine cell per polynomial step, then matrix cells.
  localparam int unsigned SC_CELLS  = 6;
  localparam int unsigned MAT_CELLS = 3;
  localparam int unsigned DEPTH     = SC_CELLS + MAT_CELLS + 1;

  // Named signed element types keep their sign when picked out of a packed array.
  typedef logic signed [31:0] q30_t;
  typedef logic signed [33:0] sum_t;
  typedef logic signed [15:0] coef_t;

  // Work data that a sine/cosine cell hands to its neighbor for one angle.
  typedef struct packed {
    logic               neg;   // quadrant negates the result
    logic signed [31:0] x;     // Q2.30 offset
    logic signed [31:0] x2;    // x squared, Q30
    logic signed [31:0] p;     // Horner accumulator, Q30
  } sc_lane_t;

  // Product of two Q30 values rounded half away from zero back to Q30.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] prod;
    logic        [63:0] mag;
    logic        [63:0] rnd;
    prod = 64'(a) * 64'(b);
    mag  = prod[63] ? 64'(-prod) : 64'(prod);
    rnd  = (mag + (64'd1 << 29)) >> 30;
    return prod[63] ? -32'(rnd) : 32'(rnd);
  endfunction

  // Q30 (up to about +-2) to the output format, rounded and saturated.
  function automatic logic signed [15:0] to_out(input logic signed [33:0] v);
    logic        [33:0] mag;
    logic        [33:0] r;
    logic signed [34:0] sr;
    logic signed [34:0] lim;
    mag = v[33] ? 34'(-v) : 34'(v);
    r   = (mag + (34'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    sr  = v[33] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    lim = 35'sd1 <<< COEF_FRAC_BITS;
    if (sr > lim) sr = lim;
    if (sr < -lim) sr = -lim;
    if (sr > 35'sd32767) sr = 35'sd32767;
    if (sr < -35'sd32768) sr = -35'sd32768;
    return sr[15:0];
  endfunction

endpackage

// File: rtl/eadcm_sc_cell.sv
// One cell of the sine/cosine chain: a single Horner step for six angles at once.
// Depends on eadcm_pkg.
module eadcm_sc_cell import eadcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2:0]            step_i,
  input  sc_lane_t [5:0]        lane_i,
  output sc_lane_t [5:0]        lane_o
);

  localparam logic [2:0] StepSq = 3'd0;
  localparam logic [2:0] StepC7 = 3'd1;
  localparam logic [2:0] StepC5 = 3'd2;
  localparam logic [2:0] StepC3 = 3'd3;
  localparam logic [2:0] StepC1 = 3'd4;
  localparam logic [2:0] StepS  = 3'd5;

  sc_lane_t [5:0] lane_d, lane_q;

  always_comb begin
    lane_d = lane_i;
    for (int i = 0; i < 6; i++) begin
      unique case (step_i)
        StepSq: begin
          lane_d[i].x2 = qmul(lane_i[i].x, lane_i[i].x);
          lane_d[i].p  = SIN_C9;
        end
        StepC7: lane_d[i].p = SIN_C7 - qmul(lane_i[i].x2, lane_i[i].p);
        StepC5: lane_d[i].p = SIN_C5 - qmul(lane_i[i].x2, lane_i[i].p);
        StepC3: lane_d[i].p = SIN_C3 - qmul(lane_i[i].x2, lane_i[i].p);
        StepC1: lane_d[i].p = SIN_C1 - qmul(lane_i[i].x2, lane_i[i].p);
        StepS: begin
          // Clamp the quarter sine to [0, 1] and apply the quadrant sign.
          lane_d[i].p = qmul(lane_i[i].x, lane_i[i].p);
          if (lane_d[i].p > Q30_ONE) lane_d[i].p = Q30_ONE;
          if (lane_d[i].p < 0) lane_d[i].p = '0;
          if (lane_i[i].neg) lane_d[i].p = -lane_d[i].p;
        end
        default: lane_d[i] = lane_i[i];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// File: rtl/eadcm_mat_cell.sv
// Matrix product cells: rotation entries built from six sines and cosines.
// Depends on eadcm_pkg.
module eadcm_mat_cell import eadcm_pkg::*; (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [1:0]   step_i,
  input  q30_t [5:0]   sc_i,
  input  sum_t [8:0]   acc_i,
  output q30_t [5:0]   sc_o,
  output sum_t [8:0]   m_o
);

  localparam logic [1:0] StepPair = 2'd0;
  localparam logic [1:0] StepTrip = 2'd1;
  localparam logic [1:0] StepSum  = 2'd2;

  // sc order: sphi, cphi, sth, cth, spsi, cpsi
  q30_t       sphi, cphi, sth, cth, spsi, cpsi;
  q30_t [5:0] sc_q;
  sum_t [8:0] m_d, m_q;

  assign sphi = sc_i[0];
  assign cphi = sc_i[1];
  assign sth  = sc_i[2];
  assign cth  = sc_i[3];
  assign spsi = sc_i[4];
  assign cpsi = sc_i[5];

  always_comb begin
    m_d = '0;
    unique case (step_i)
      StepPair: begin
        // Slot 0/1 hold ss and cs for the triple products.
        m_d[0] = 34'(qmul(sphi, sth));
        m_d[1] = 34'(qmul(cphi, sth));
        m_d[2] = 34'(qmul(cphi, spsi));
        m_d[3] = 34'(qmul(sphi, spsi));
        m_d[4] = 34'(qmul(cphi, cpsi));
        m_d[5] = 34'(qmul(sphi, cpsi));
        m_d[6] = 34'(qmul(cth, cpsi));
      end
      StepTrip: begin
        m_d[0] = 34'(qmul(32'(acc_i[0]), cpsi));
        m_d[1] = 34'(qmul(32'(acc_i[1]), cpsi));
        m_d[2] = 34'(qmul(32'(acc_i[0]), spsi));
        m_d[3] = 34'(qmul(32'(acc_i[1]), spsi));
        m_d[4] = acc_i[2];
        m_d[5] = acc_i[3];
        m_d[6] = acc_i[4];
        m_d[7] = acc_i[5];
        m_d[8] = acc_i[6];
      end
      StepSum: begin
        // Entries leave in row order; the last row comes straight from the angles.
        m_d[0] = acc_i[8];
        m_d[1] = acc_i[0] - acc_i[4];
        m_d[2] = acc_i[1] + acc_i[5];
        m_d[3] = 34'(qmul(cth, spsi));
        m_d[4] = acc_i[2] + acc_i[6];
        m_d[5] = acc_i[3] - acc_i[7];
        m_d[6] = 34'(-sth);
        m_d[7] = 34'(qmul(sphi, cth));
        m_d[8] = 34'(qmul(cphi, cth));
      end
      default: m_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q  <= m_d;
      sc_q <= sc_i;
    end
  end

  assign sc_o = sc_q;
  assign m_o  = m_q;

endmodule

// File: rtl/euler_angles_to_rotation_matrix_top.sv
// Top level: Euler Z-Y-X angles to direction cosine matrix, fully pipelined.
// Depends on eadcm_pkg, eadcm_sc_cell and eadcm_mat_cell.
//
//  Channel | Signals                                  | Direction
//  angles  | in_valid_i, in_stall_o, *_angle_i        | in
//  matrix  | out_valid_o, out_stall_i, m_row*_col*_o  | out
//
// Each transaction passes through a chain of ten stages: six Horner-step
// sine/cosine cells, then three matrix stages and an output stage.
// One transaction enters per cycle unless a valid output is stalled; the whole chain advances together.
// A stalled valid output holds the chain, and the input stall follows it.
// Reset clears the stage valid bits only.
module euler_angles_to_rotation_matrix_top import eadcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] roll_angle_i,
  input  logic [15:0] pitch_angle_i,
  input  logic [15:0] yaw_angle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] m_row0_col0_o,
  output logic signed [15:0] m_row0_col1_o,
  output logic signed [15:0] m_row0_col2_o,
  output logic signed [15:0] m_row1_col0_o,
  output logic signed [15:0] m_row1_col1_o,
  output logic signed [15:0] m_row1_col2_o,
  output logic signed [15:0] m_row2_col0_o,
  output logic signed [15:0] m_row2_col1_o,
  output logic signed [15:0] m_row2_col2_o
);

  logic [DEPTH-1:0] vld_d, vld_q;
  logic             adv;
  sc_lane_t [5:0]   lane [SC_CELLS+1];
  logic [15:0]      ang [6];
  q30_t [5:0]       sc_v;
  q30_t [5:0]       sc_m [MAT_CELLS+1];
  sum_t [8:0]       m_m [MAT_CELLS+1];
  coef_t [8:0]      out_d, out_q;

  // A bubble at the end lets the chain move even under stall.
  assign adv        = !(vld_q[DEPTH-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    vld_d = vld_q;
    if (adv) vld_d = {vld_q[DEPTH-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ang[0] = roll_angle_i;
  assign ang[1] = roll_angle_i + 16'd16384;
  assign ang[2] = pitch_angle_i;
  assign ang[3] = pitch_angle_i + 16'd16384;
  assign ang[4] = yaw_angle_i;
  assign ang[5] = yaw_angle_i + 16'd16384;

  always_comb begin
    logic [14:0] f;
    for (int i = 0; i < 6; i++) begin
      f = ang[i][14] ? (15'd16384 - {1'b0, ang[i][13:0]}) : {1'b0, ang[i][13:0]};
      lane[0][i].neg = ang[i][15];
      lane[0][i].x   = {1'b0, f, 16'd0};
      lane[0][i].x2  = '0;
      lane[0][i].p   = '0;
    end
  end

  for (genvar c = 0; c < SC_CELLS; c++) begin : g_sc
    eadcm_sc_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (3'(c)),
      .lane_i (lane[c]),
      .lane_o (lane[c+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 6; i++) sc_v[i] = lane[SC_CELLS][i].p;
  end

  assign sc_m[0] = sc_v;
  assign m_m[0]  = '0;

  for (genvar c = 0; c < MAT_CELLS; c++) begin : g_mat
    eadcm_mat_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (2'(c)),
      .sc_i   (sc_m[c]),
      .acc_i  (m_m[c]),
      .sc_o   (sc_m[c+1]),
      .m_o    (m_m[c+1])
    );
  end

  // Final stage: the last matrix cell hands over all nine entries in row order.
  always_comb begin
    for (int i = 0; i < 9; i++) out_d[i] = to_out(m_m[MAT_CELLS][i]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o   = vld_q[DEPTH-1];
  assign m_row0_col0_o = out_q[0];
  assign m_row0_col1_o = out_q[1];
  assign m_row0_col2_o = out_q[2];
  assign m_row1_col0_o = out_q[3];
  assign m_row1_col1_o = out_q[4];
  assign m_row1_col2_o = out_q[5];
  assign m_row2_col0_o = out_q[6];
  assign m_row2_col1_o = out_q[7];
  assign m_row2_col2_o = out_q[8];

endmodule

// File: verif/testbench.sv
// Testbench for the Euler angle to direction cosine matrix block.
// Sends angle transactions, predicts each matrix in fixed point and checks it.
// Depends on eadcm_pkg and the RTL top level.
`timescale 1ns / 100ps

module testbench import eadcm_pkg::*; ();

  typedef struct packed {
    logic [15:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  } matrix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] roll_angle_i = '0;
  logic [15:0] pitch_angle_i = '0;
  logic [15:0] yaw_angle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [15:0] m_row0_col0_o, m_row0_col1_o, m_row0_col2_o;
  logic signed [15:0] m_row1_col0_o, m_row1_col1_o, m_row1_col2_o;
  logic signed [15:0] m_row2_col0_o, m_row2_col1_o, m_row2_col2_o;

  matrix_t     matrix_queue[$];
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned matrix_count = 0;
  int unsigned angle_count = 0;
  longint unsigned cycle_count = 0;

  euler_angles_to_rotation_matrix_top i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Rounded shift right, half away from zero.
  function automatic longint round_shift(input longint v, input int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint quarter_wave(input longint f);
    longint x, x2, p, s;
    x  = f <<< 16;
    x2 = q30_product(x, x);
    p  = 172272;
    p  = 5026995 - q30_product(x2, p);
    p  = 85569306 - q30_product(x2, p);
    p  = 693598668 - q30_product(x2, p);
    p  = 1686629713 - q30_product(x2, p);
    s  = q30_product(x, p);
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < 0) s = 0;
    return s;
  endfunction

  function automatic longint angle_sine(input logic [15:0] a);
    longint s;
    s = a[14] ? quarter_wave(16384 - a[13:0]) : quarter_wave(a[13:0]);
    return a[15] ? -s : s;
  endfunction

  function automatic logic [15:0] to_coef(input longint v);
    longint r, lim;
    r   = round_shift(v, 30 - COEF_FRAC_BITS);
    lim = longint'(1) << COEF_FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic matrix_t predict_matrix(input logic [15:0] phi, th, psi);
    longint sphi, cphi, sth, cth, spsi, cpsi, ss, cs;
    matrix_t m;
    sphi = angle_sine(phi);
    cphi = angle_sine(phi + 16'd16384);
    sth  = angle_sine(th);
    cth  = angle_sine(th + 16'd16384);
    spsi = angle_sine(psi);
    cpsi = angle_sine(psi + 16'd16384);
    ss   = q30_product(sphi, sth);
    cs   = q30_product(cphi, sth);
    m.e00 = to_coef(q30_product(cth, cpsi));
    m.e01 = to_coef(q30_product(ss, cpsi) - q30_product(cphi, spsi));
    m.e02 = to_coef(q30_product(cs, cpsi) + q30_product(sphi, spsi));
    m.e10 = to_coef(q30_product(cth, spsi));
    m.e11 = to_coef(q30_product(ss, spsi) + q30_product(cphi, cpsi));
    m.e12 = to_coef(q30_product(cs, spsi) - q30_product(sphi, cpsi));
    m.e20 = to_coef(-sth);
    m.e21 = to_coef(q30_product(sphi, cth));
    m.e22 = to_coef(q30_product(cphi, cth));
    return m;
  endfunction

  // Sends one angle transaction; valid stays high across back-to-back sends.
  task automatic send_angles(input logic [15:0] phi, th, psi);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    roll_angle_i  <= phi;
    pitch_angle_i <= th;
    yaw_angle_i   <= psi;
    matrix_queue = {matrix_queue, predict_matrix(phi, th, psi)};
    angle_count++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    matrix_t got, want;
    cycle_count++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {m_row0_col0_o, m_row0_col1_o, m_row0_col2_o,
             m_row1_col0_o, m_row1_col1_o, m_row1_col2_o,
             m_row2_col0_o, m_row2_col1_o, m_row2_col2_o};
      matrix_count++;
      if (matrix_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected matrix %h", got);
      end else begin
        want = matrix_queue.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Matrix mismatch: expected %h, actual %h", want, got);
        end
      end
    end
    if (cycle_count > 200000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (matrix_queue.size() != 0) @(posedge clk_i);
  endtask

  // Quadrant boundaries, extremes and the sign bit of each angle.
  task automatic test_directed();
    logic [15:0] corner[8];
    corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
               16'h7FFF, 16'hFFFF, 16'h3FFF, 16'h2000};
    for (int i = 0; i < 8; i++) send_angles(corner[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) send_angles(16'h0000, corner[i], 16'h0000);
    for (int i = 0; i < 8; i++) send_angles(16'h1234, 16'hABCD, corner[i]);
    wait_drained();
  endtask

  // Random angles under one idling mix; some land near quadrant edges.
  task automatic test_random(input int n, input int unsigned idle, stall);
    logic [15:0] a[3];
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      foreach (a[k]) begin
        a[k] = 16'($urandom());
        if ($urandom_range(7, 0) == 0)
          a[k] = {a[k][15:14], $urandom_range(1, 0) ? 14'h0000 : 14'h3FFF}
                 ^ 16'($urandom_range(1, 0));
      end
      send_angles(a[0], a[1], a[2]);
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 0, 0);
    test_random(200, 81, 0);
    test_random(200, 0, 81);
    test_random(200, 10, 10);
    receiver_stall_pct = 0;
    repeat (4 * DEPTH) @(posedge clk_i);
    $display("Sent %0d angle transactions and checked %0d matrices", angle_count,
             matrix_count);
    $display("Idling phases: none, sender 81%%, receiver 81%%, both 10%%");
    if (mismatch_count == 0 && matrix_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d matrices missing", mismatch_count,
               matrix_queue.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
